// ===== design/pcd_pkg.sv =====
`default_nettype none
package pcd_pkg;
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_ZERO = 2'd1;
  localparam logic [1:0] FUNC_ADC  = 2'd2;
  localparam logic [1:0] FUNC_CHAN = 2'd3;

  localparam logic [1:0] CFG_ZERO_OFFSET = 2'd0;
  localparam logic [1:0] CFG_MEAS_EN     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd30000;
  localparam int SUM_W = 36;
  localparam int RMS_W = 14;
  localparam logic [RMS_W-1:0] RMS_MAX = 14'd16383;
  localparam int REF_MV_X1000 = 3300000;
  localparam int SENSE_GAIN_MV = 400;

  // Request to the RMS math unit and its reply.
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  sum;
    logic [12:0]       count;
  } rms_req_t;

  typedef struct packed {
    logic              done;
    logic [RMS_W-1:0]  value;
  } rms_rsp_t;
endpackage
`default_nettype wire

// ===== design/pcd_rms_unit.sv =====
`default_nettype none
// Sequencer for a restoring divide of the sum by the sample count, then a
// digit-by-digit square root, then a constant multiply and shift for the
// milliamp scale; a zero sample count gives a zero result directly.
module pcd_rms_unit #(
  parameter int ADC_BITS = 12
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pcd_pkg::rms_req_t req,
  output pcd_pkg::rms_rsp_t    rsp
);
  localparam int SW = pcd_pkg::SUM_W;
  localparam int RW = 26;          // root of a 52-bit radicand
  localparam int VW = 52;          // mean << 16 fits in 52 bits
  localparam int MW = 23;          // 3300000 needs 22 bits, 23 keeps it positive
  localparam int PW = RW + MW;
  localparam int SH = ADC_BITS + 8;
  // 3300000 / (400 * 2^ADC_BITS * 256) = 8250 / 2^(ADC_BITS+8)
  localparam logic [MW-1:0] SCALE = MW'(pcd_pkg::REF_MV_X1000 / pcd_pkg::SENSE_GAIN_MV);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [5:0]    step_r, step_nxt;
  logic [SW-1:0] quo_r, quo_nxt;
  logic [12:0]   rem_r, rem_nxt;
  logic [12:0]   den_r, den_nxt;
  logic [VW-1:0] rad_r, rad_nxt;
  logic [RW+1:0] srem_r, srem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [pcd_pkg::RMS_W-1:0] val_r, val_nxt;

  logic [12:0]   dshift;
  logic [RW+1:0] strial, scand;
  logic [PW-1:0] scaled;

  always_comb begin
    dshift = {rem_r[11:0], quo_r[SW-1]};
    scand  = {srem_r[RW-1:0], rad_r[VW-1 -: 2]};
    strial = {root_r, 2'b01};
    scaled = prod_r >> SH;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    rad_nxt   = rad_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    prod_nxt  = prod_r;
    val_nxt   = val_r;
    rsp.done  = 1'b0;
    rsp.value = val_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          if (req.count == 13'd0) begin
            val_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            quo_nxt   = req.sum;
            den_nxt   = req.count;
            rem_nxt   = '0;
            step_nxt  = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (dshift >= den_r) begin
          rem_nxt = dshift - den_r;
          quo_nxt = {quo_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = dshift;
          quo_nxt = {quo_r[SW-2:0], 1'b0};
        end
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(SW - 1)) begin
          rad_nxt   = {quo_nxt, 16'd0};
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        // One root bit per cycle from the top pair of radicand bits.
        if (scand >= strial) begin
          srem_nxt = scand - strial;
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          srem_nxt = scand;
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        rad_nxt  = {rad_r[VW-3:0], 2'b00};
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(RW - 1)) state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = PW'(root_r) * PW'(SCALE);
        state_nxt = S_OUT;
        step_nxt  = '0;
      end
      S_OUT: begin
        if (step_r == 6'd0 && den_r != 13'd0) begin
          val_nxt  = (scaled > PW'(pcd_pkg::RMS_MAX)) ? pcd_pkg::RMS_MAX
                                                      : scaled[pcd_pkg::RMS_W-1:0];
          step_nxt = 6'd1;
        end else begin
          rsp.done  = 1'b1;
          rsp.value = val_r;
          state_nxt = S_IDLE;
          den_nxt   = '0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      den_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      den_r   <= den_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    rad_r  <= rad_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    prod_r <= prod_nxt;
    val_r  <= val_nxt;
  end
endmodule
`default_nettype wire

// ===== design/phase_cut_dimmer_rms_meter.sv =====
`default_nettype none
// Trailing-edge phase dimmer with a half-cycle RMS current meter.
// Input requests on in_* carry one event each: a tick, a zero crossing, an
// ADC sample or a channel setting. Every request yields exactly one result
// on out_* with the lamp states, the RMS current, the period and a flag set
// when the RMS value was recomputed.
// Ticks, samples and channel writes update the state in S_EXEC and run
// the lamp turn-off pass in S_DIM, then the result is shown in S_OUT.
// The next request is taken the cycle after the result is accepted; no
// new request is taken while an earlier one is still in progress.
// A zero crossing runs the RMS unit: a 36-step divide, a 26-step square
// root, a scale step and two output steps; with no samples taken or
// measuring off it goes straight to its output with a zero value.
// If the receiver stalls, the result is held and in_tready stays low.
// Configuration is written through cfg_*, by the user only while idle; the block does not check.
// Reset (rst_n low, synchronous) clears the counters, the accumulator, all
// lamps, the dim table and the RMS value, and sets the timeout to 30000.
module phase_cut_dimmer_rms_meter #(
  parameter int CHANNELS     = 18,
  parameter int SAMPLE_LIMIT = 2048,
  parameter int ADC_BITS     = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // func[1:0], adc_value[13:2], channel[18:14], dim_ticks[34:19], force_on[35]
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // lamp_on[17:0], rms_milliamps[31:18], period_ticks[47:32], rms_update[48]
  output logic [55:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RMS  = 3'd2;
  localparam logic [2:0] S_DIM  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [11:0] zero_r;
  logic        meas_r;
  logic [15:0] tmo_r;
  logic [15:0] live_r, last_r;
  logic [12:0] scnt_r;
  logic [pcd_pkg::SUM_W-1:0] sum_r;
  logic [CHANNELS-1:0] lamp_r;
  logic [15:0] dim_r [CHANNELS];
  logic [pcd_pkg::RMS_W-1:0] rms_r;
  logic [35:0] item_r;
  logic        upd_r;

  pcd_pkg::rms_req_t req;
  pcd_pkg::rms_rsp_t rsp;

  logic [1:0]  f_func;
  logic [11:0] f_adc;
  logic [4:0]  f_ch;
  logic [15:0] f_dim;
  logic        f_force;
  logic [16:0] nxt_live;
  logic [11:0] diff;
  logic [23:0] sq;
  logic [CHANNELS-1:0] dimmed, off_mask;

  assign f_func  = item_r[1:0];
  assign f_adc   = item_r[13:2];
  assign f_ch    = item_r[18:14];
  assign f_dim   = item_r[34:19];
  assign f_force = item_r[35];

  assign nxt_live = {1'b0, live_r} + 17'd1;
  assign diff = (f_adc >= zero_r) ? f_adc - zero_r : zero_r - f_adc;
  assign sq   = 24'(diff) * 24'(diff);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      dimmed[i]   = dim_r[i] != 16'd0;
      off_mask[i] = dimmed[i] && live_r >= dim_r[i];
    end
  end

  assign req.start = (state_r == S_EXEC) && (f_func == pcd_pkg::FUNC_ZERO);
  assign req.sum   = sum_r;
  assign req.count = meas_r ? scnt_r : 13'd0;

  pcd_rms_unit #(.ADC_BITS(ADC_BITS)) u_rms (
    .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp)
  );

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = state_r == S_OUT;
  assign out_tdata  = {7'd0, upd_r, last_r, rms_r, 18'(lamp_r)};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = (f_func == pcd_pkg::FUNC_ZERO) ? S_RMS : S_DIM;
      S_RMS:  if (rsp.done) state_nxt = S_DIM;
      S_DIM:  state_nxt = S_OUT;
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      zero_r  <= '0;
      meas_r  <= 1'b0;
      tmo_r   <= pcd_pkg::TIMEOUT_RESET;
      live_r  <= '0;
      last_r  <= '0;
      scnt_r  <= '0;
      sum_r   <= '0;
      lamp_r  <= '0;
      rms_r   <= '0;
      upd_r   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) dim_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pcd_pkg::CFG_ZERO_OFFSET: zero_r <= cfg_data[11:0];
          pcd_pkg::CFG_MEAS_EN:     meas_r <= cfg_data[0];
          pcd_pkg::CFG_TIMEOUT:     tmo_r  <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_EXEC) begin
        upd_r <= 1'b0;
        unique case (f_func)
          pcd_pkg::FUNC_TICK: begin
            if (nxt_live > {1'b0, tmo_r}) begin
              live_r <= '0;
              last_r <= '0;
            end else begin
              live_r <= nxt_live[15:0];
            end
          end
          pcd_pkg::FUNC_ZERO: begin
            last_r <= live_r;
            live_r <= '0;
            lamp_r <= lamp_r | dimmed;
            upd_r  <= 1'b1;
          end
          pcd_pkg::FUNC_ADC: begin
            if (meas_r && last_r != 16'd0 && scnt_r < 13'(SAMPLE_LIMIT)) begin
              sum_r  <= sum_r + pcd_pkg::SUM_W'(sq);
              scnt_r <= scnt_r + 13'd1;
            end
          end
          pcd_pkg::FUNC_CHAN: begin
            if (32'(f_ch) < CHANNELS) begin
              dim_r[f_ch[CW-1:0]]  <= f_dim;
              lamp_r[f_ch[CW-1:0]] <= f_force;
            end
          end
          default: ;
        endcase
      end
      if (state_r == S_RMS && rsp.done) begin
        rms_r  <= rsp.value;
        scnt_r <= '0;
        sum_r  <= '0;
      end
      // Lamp turn-off pass on the updated state before the result is shown.
      if (state_r == S_DIM) lamp_r <= lamp_r & ~off_mask;
    end
    if (state_r == S_IDLE && in_tvalid) item_r <= in_tdata[35:0];
  end
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  typedef struct {
    logic [1:0]  func;
    logic [11:0] adc;
    logic [4:0]  chan;
    logic [15:0] dim;
    logic        force_on;
  } dim_req_t;

  typedef struct {
    logic [17:0] lamps;
    logic [13:0] rms;
    logic [15:0] period;
    logic        upd;
  } meter_res_t;

  typedef struct {
    dim_req_t   req;
    logic       typed;
    meter_res_t res;
  } stim_row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [55:0] out_tdata;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Local copy of the block's registers and state.
  logic [11:0] m_offset;
  logic        m_enable;
  logic [15:0] m_timeout;
  logic [15:0] m_live, m_last;
  logic [11:0] m_samples;
  logic [35:0] m_sumsq;
  logic [17:0] m_lamps;
  logic [15:0] m_dim [18];
  logic [13:0] m_rms;

  meter_res_t  results_due[$];
  stim_row_t   rows_a[$], rows_b[$];
  int          errors = 0;
  int          tx_idle_pct = 0, rx_idle_pct = 0;
  int          rx_hold = 0;

  logic [15:0] offs [7] = '{16'd0, 16'd4095, 16'd2048, 16'd0, 16'd0, 16'd1234, 16'd100};
  logic        ens  [7] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
  logic [15:0] touts[7] = '{16'd30000, 16'd50, 16'd20, 16'd0, 16'd65535, 16'd1, 16'd200};

  phase_cut_dimmer_rms_meter dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #20ms;
    $display("phase_cut_dimmer_rms_meter: mismatch");
    $finish;
  end

  function automatic logic [13:0] half_cycle_rms();
    longint unsigned v, root, b, val;
    if (!m_enable || m_samples == 0) return '0;
    v = (longint'(m_sumsq) / longint'(m_samples)) << 16;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    val = root * 64'd3300000 / 64'd419430400;
    return (val > 16383) ? 14'd16383 : val[13:0];
  endfunction

  function automatic meter_res_t step_dimmer(dim_req_t r);
    meter_res_t o;
    logic [16:0] nxt;
    logic [11:0] dev;
    o.upd = 0;
    case (r.func)
      pcd_pkg::FUNC_TICK: begin
        nxt = m_live + 17'd1;
        if (nxt > m_timeout) begin
          m_live = 0;
          m_last = 0;
        end else begin
          m_live = nxt[15:0];
        end
      end
      pcd_pkg::FUNC_ZERO: begin
        m_last = m_live;
        m_live = 0;
        for (int i = 0; i < 18; i++) if (m_dim[i] != 0) m_lamps[i] = 1'b1;
        m_rms = half_cycle_rms();
        m_samples = 0;
        m_sumsq = 0;
        o.upd = 1;
      end
      pcd_pkg::FUNC_ADC: begin
        if (m_enable && m_last != 0 && m_samples < 2048) begin
          dev = (r.adc >= m_offset) ? r.adc - m_offset : m_offset - r.adc;
          m_sumsq = m_sumsq + 36'(dev) * 36'(dev);
          m_samples++;
        end
      end
      default: begin
        if (r.chan < 18) begin
          m_dim[r.chan] = r.dim;
          m_lamps[r.chan] = r.force_on;
        end
      end
    endcase
    for (int i = 0; i < 18; i++)
      if (m_lamps[i] && m_dim[i] != 0 && m_live >= m_dim[i]) m_lamps[i] = 1'b0;
    o.lamps = m_lamps;
    o.rms = m_rms;
    o.period = m_last;
    return o;
  endfunction

  function automatic dim_req_t random_request();
    dim_req_t r;
    int pick;
    pick = $urandom_range(99);
    r.func = (pick < 50) ? pcd_pkg::FUNC_TICK : (pick < 80) ? pcd_pkg::FUNC_ADC
           : (pick < 86) ? pcd_pkg::FUNC_ZERO : pcd_pkg::FUNC_CHAN;
    r.adc = $urandom_range(4095);
    r.chan = $urandom_range(31);
    r.dim = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    r.force_on = $urandom_range(1);
    return r;
  endfunction

  task automatic send_request(dim_req_t r, logic typed, meter_res_t typed_res);
    meter_res_t p;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, r.force_on, r.dim, r.chan, r.adc, r.func};
    do @(posedge clk); while (!in_tready);
    p = step_dimmer(r);
    results_due.push_back(typed ? typed_res : p);
  endtask

  task automatic run_rows(ref stim_row_t rows[$]);
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pcd_pkg::CFG_ZERO_OFFSET: m_offset = val[11:0];
      pcd_pkg::CFG_MEAS_EN:     m_enable = val[0];
      pcd_pkg::CFG_TIMEOUT:     m_timeout = val;
      default: ;
    endcase
  endtask

  task automatic add_row(ref stim_row_t rows[$], input logic [1:0] f, input int adc,
                         input int ch, input int dim, input logic fo,
                         input logic typed = 0, input meter_res_t res = '{0, 0, 0, 0});
    stim_row_t s;
    s.req = '{f, adc[11:0], ch[4:0], dim[15:0], fo};
    s.typed = typed;
    s.res = res;
    rows.push_back(s);
  endtask

  // Each result is compared with the oldest expectation.
  always @(posedge clk) begin
    meter_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        e = results_due.pop_front();
        if (out_tdata[17:0] !== e.lamps) begin
          $error("lamp_on expected %h actual %h", e.lamps, out_tdata[17:0]);
          errors++;
        end
        if (out_tdata[31:18] !== e.rms) begin
          $error("rms_milliamps expected %0d actual %0d", e.rms, out_tdata[31:18]);
          errors++;
        end
        if (out_tdata[47:32] !== e.period) begin
          $error("period_ticks expected %0d actual %0d", e.period, out_tdata[47:32]);
          errors++;
        end
        if (out_tdata[48] !== e.upd) begin
          $error("rms_update expected %0d actual %0d", e.upd, out_tdata[48]);
          errors++;
        end
      end
    end
  end

  // Receiver side; a nonzero hold keeps it stalled until the hold counts down to zero.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    m_offset = 0; m_enable = 0; m_timeout = pcd_pkg::TIMEOUT_RESET;
    m_live = 0; m_last = 0; m_samples = 0; m_sumsq = 0; m_lamps = 0; m_rms = 0;
    foreach (m_dim[i]) m_dim[i] = 0;

    // Defaults after reset: measuring off, timeout at its reset value.
    add_row(rows_a, pcd_pkg::FUNC_TICK, 0, 0, 0, 0, 1, '{18'd0, 14'd0, 16'd0, 1'b0});
    add_row(rows_a, pcd_pkg::FUNC_ZERO, 0, 0, 0, 0, 1, '{18'd0, 14'd0, 16'd1, 1'b1});
    add_row(rows_a, pcd_pkg::FUNC_CHAN, 0, 17, 16'hFFFF, 1);
    add_row(rows_a, pcd_pkg::FUNC_CHAN, 0, 31, 5, 1);
    add_row(rows_a, pcd_pkg::FUNC_CHAN, 0, 18, 7, 1);
    add_row(rows_a, pcd_pkg::FUNC_CHAN, 0, 0, 2, 0);
    add_row(rows_a, pcd_pkg::FUNC_ADC, 4095, 0, 0, 0);
    add_row(rows_a, pcd_pkg::FUNC_ZERO, 0, 0, 0, 0);
    add_row(rows_a, pcd_pkg::FUNC_TICK, 0, 0, 0, 0);
    add_row(rows_a, pcd_pkg::FUNC_TICK, 0, 0, 0, 0);
    add_row(rows_a, pcd_pkg::FUNC_CHAN, 0, 5, 0, 1);
    // Measuring on with full-scale samples, a sample with no period known, then ticks past the timeout.
    add_row(rows_b, pcd_pkg::FUNC_TICK, 0, 0, 0, 0);
    add_row(rows_b, pcd_pkg::FUNC_ZERO, 0, 0, 0, 0);
    add_row(rows_b, pcd_pkg::FUNC_ADC, 4095, 0, 0, 0);
    add_row(rows_b, pcd_pkg::FUNC_ADC, 4095, 0, 0, 0);
    add_row(rows_b, pcd_pkg::FUNC_ZERO, 0, 0, 0, 0);
    add_row(rows_b, pcd_pkg::FUNC_ADC, 4095, 0, 0, 0);
    add_row(rows_b, pcd_pkg::FUNC_ZERO, 0, 0, 0, 0);
    add_row(rows_b, pcd_pkg::FUNC_TICK, 0, 0, 0, 0);
    add_row(rows_b, pcd_pkg::FUNC_TICK, 0, 0, 0, 0);
    add_row(rows_b, pcd_pkg::FUNC_TICK, 0, 0, 0, 0);
    add_row(rows_b, pcd_pkg::FUNC_TICK, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 22;
    rx_idle_pct = 47;
    run_rows(rows_a);
    wait_drained();
    write_reg(pcd_pkg::CFG_ZERO_OFFSET, 16'd0);
    write_reg(pcd_pkg::CFG_MEAS_EN, 16'd1);
    write_reg(pcd_pkg::CFG_TIMEOUT, 16'd3);
    run_rows(rows_b);

    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      write_reg(pcd_pkg::CFG_ZERO_OFFSET,
                (ph == 3 || ph == 4) ? 16'($urandom_range(4095)) : offs[ph]);
      write_reg(pcd_pkg::CFG_MEAS_EN, 16'(ens[ph]));
      write_reg(pcd_pkg::CFG_TIMEOUT, touts[ph]);
      tx_idle_pct = (ph < 3) ? 22 : (ph < 6) ? 47 : 0;
      rx_idle_pct = (ph < 3) ? 47 : (ph < 6) ? 22 : 0;
      if (ph == 1) rx_hold = 400;
      for (int k = 0; k < 145; k++) send_request(random_request(), 0, '{0, 0, 0, 0});
    end
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("phase_cut_dimmer_rms_meter: match");
    end else begin
      $display("phase_cut_dimmer_rms_meter: mismatch");
    end
    $finish;
  end
endmodule
